// ===== rtl/flat_field_gain_map_macros.svh =====
// ---------------------------------------------------------------------------
// Flat-field gain map assertion macros
// Concurrent check wrappers; compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef FLAT_FIELD_GAIN_MAP_MACROS_SVH
`define FLAT_FIELD_GAIN_MAP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define FFGM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle
`define FFGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFGM_ASSERT(label, prop, msg)
`define FFGM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/ffgm_pkg.sv =====
// ---------------------------------------------------------------------------
// Flat-field gain map package
// Shared widths, limits, codes and the readout request/response words.
// ---------------------------------------------------------------------------
package ffgm_pkg;

    localparam int IDX_W   = 16;
    localparam int DATA_W  = 16;
    localparam int SUM_W   = 24;
    localparam int TOTAL_W = 40;
    localparam int GAIN_W  = 20;
    localparam int COUNT_W = 17;
    localparam int PROD_W  = SUM_W + COUNT_W;
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = PROD_W + FRAC_W;
    localparam int STEP_W  = $clog2(GAIN_W);

    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [GAIN_W-1:0]  GAIN_MAX    = {GAIN_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_RESET = 17'h10000;

    // Item operation codes
    typedef enum logic [0:0] {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_PIXEL_COUNT = 1'b0,
        CFG_DARK_ENABLE = 1'b1
    } cfg_idx_t;

    // Result status codes
    typedef enum logic [0:0] {
        STAT_OK         = 1'b0,
        STAT_ZERO_TOTAL = 1'b1
    } status_t;

    // Top-level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_DIV
    } state_t;

    // Readout unit phases
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_CHK,
        DV_STEP
    } div_phase_t;

    typedef struct packed {
        logic               valid;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } rd_req_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] gain;
        status_t           status;
        logic              last;
    } rd_rsp_t;

endpackage

// ===== rtl/ffgm_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ---------------------------------------------------------------------------
module ffgm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word (old data on a clash)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ffgm_acc.sv =====
// ---------------------------------------------------------------------------
// Flat-field accumulator update
// Read-modify-write of the per-pixel sums with write forwarding, and the
// saturating grand total.
// ---------------------------------------------------------------------------
module ffgm_acc #(
    parameter int ADDR_W = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_issue,
    input  logic                         acc_issue,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [ffgm_pkg::DATA_W-1:0]  flat_value,
    input  logic [ffgm_pkg::DATA_W-1:0]  dark_value,
    input  logic                         first_frame,
    input  logic                         dark_enable,
    input  logic [ffgm_pkg::SUM_W-1:0]   rdata,
    output logic                         mem_we,
    output logic [ADDR_W-1:0]            mem_waddr,
    output logic [ffgm_pkg::SUM_W-1:0]   mem_wdata,
    output logic [ffgm_pkg::SUM_W-1:0]   sum_rd,
    output logic [ffgm_pkg::TOTAL_W-1:0] total
);

    logic                         s1_valid_reg;
    logic [ADDR_W-1:0]            s1_addr_reg;
    logic [ffgm_pkg::DATA_W-1:0]  s1_corr_reg;
    logic                         s1_first_reg;
    logic                         s1_clear_reg;
    logic                         fwd_hit_reg;
    logic [ffgm_pkg::SUM_W-1:0]   fwd_data_reg;
    logic [ffgm_pkg::TOTAL_W-1:0] total_reg;
    logic [ffgm_pkg::TOTAL_W-1:0] total_next;

    logic [ffgm_pkg::DATA_W-1:0]  corr;
    logic [ffgm_pkg::SUM_W:0]     sum_wide;
    logic [ffgm_pkg::SUM_W-1:0]   new_sum;
    logic [ffgm_pkg::DATA_W-1:0]  added;
    logic [ffgm_pkg::TOTAL_W-1:0] total_base;
    logic [ffgm_pkg::TOTAL_W:0]   total_wide;

    // Dark-correct the incoming word, floored at zero
    always_comb
    begin
        if (dark_enable)
        begin
            corr = (flat_value > dark_value) ? (flat_value - dark_value) : '0;
        end
        else
        begin
            corr = flat_value;
        end
    end

    // Control of the write-back stage, forwarding flag and grand total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= acc_issue;
            if (rd_issue)
            begin
                fwd_hit_reg <= mem_we && (mem_waddr == addr);
            end
            total_reg <= total_next;
        end
    end

    // Hold the payload of the word in flight
    always_ff @(posedge clk)
    begin
        if (acc_issue)
        begin
            s1_addr_reg  <= addr;
            s1_corr_reg  <= corr;
            s1_first_reg <= first_frame;
            s1_clear_reg <= first_frame && (addr == '0);
        end
        if (rd_issue)
        begin
            fwd_data_reg <= mem_wdata;
        end
    end

    // Take the write that raced the read, else the RAM word
    assign sum_rd = fwd_hit_reg ? fwd_data_reg : rdata;

    // Add into the pixel sum with saturation
    always_comb
    begin
        sum_wide = {1'b0, sum_rd} + (ffgm_pkg::SUM_W+1)'(s1_corr_reg);
        if (s1_first_reg)
        begin
            new_sum = ffgm_pkg::SUM_W'(s1_corr_reg);
        end
        else if (sum_wide[ffgm_pkg::SUM_W])
        begin
            new_sum = ffgm_pkg::SUM_MAX;
        end
        else
        begin
            new_sum = sum_wide[ffgm_pkg::SUM_W-1:0];
        end
        added = s1_first_reg ? s1_corr_reg : ffgm_pkg::DATA_W'(new_sum - sum_rd);
    end

    // Restart or advance the grand total, saturating
    always_comb
    begin
        total_base = s1_clear_reg ? '0 : total_reg;
        total_wide = {1'b0, total_base} + (ffgm_pkg::TOTAL_W+1)'(added);
        total_next = total_reg;
        if (s1_valid_reg)
        begin
            total_next = total_wide[ffgm_pkg::TOTAL_W] ? ffgm_pkg::TOTAL_MAX
                                                       : total_wide[ffgm_pkg::TOTAL_W-1:0];
        end
    end

    assign mem_we    = s1_valid_reg;
    assign mem_waddr = s1_addr_reg;
    assign mem_wdata = new_sum;
    assign total     = total_reg;

endmodule

// ===== rtl/ffgm_div.sv =====
// ---------------------------------------------------------------------------
// Flat-field gain readout unit
// Forms sum * count * 2^16, checks for zero total and saturation, then runs a
// restoring division of one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "flat_field_gain_map_macros.svh"

module ffgm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ffgm_pkg::rd_req_t req,
    output ffgm_pkg::rd_rsp_t rsp
);

    ffgm_pkg::div_phase_t                phase_reg;
    ffgm_pkg::div_phase_t                phase_next;
    logic [ffgm_pkg::STEP_W-1:0]         step_reg;
    logic [ffgm_pkg::STEP_W-1:0]         step_next;
    logic [ffgm_pkg::SUM_W-1:0]          sum_reg;
    logic [ffgm_pkg::SUM_W-1:0]          sum_next;
    logic [ffgm_pkg::COUNT_W-1:0]        count_reg;
    logic [ffgm_pkg::COUNT_W-1:0]        count_next;
    logic [ffgm_pkg::TOTAL_W-1:0]        total_reg;
    logic [ffgm_pkg::TOTAL_W-1:0]        total_next;
    logic                                last_reg;
    logic                                last_next;
    logic [ffgm_pkg::NUM_W-1:0]          num_reg;
    logic [ffgm_pkg::NUM_W-1:0]          num_next;
    logic [ffgm_pkg::TOTAL_W-1:0]        rem_reg;
    logic [ffgm_pkg::TOTAL_W-1:0]        rem_next;
    logic [ffgm_pkg::GAIN_W-1:0]         lo_reg;
    logic [ffgm_pkg::GAIN_W-1:0]         lo_next;
    logic [ffgm_pkg::GAIN_W-1:0]         quo_reg;
    logic [ffgm_pkg::GAIN_W-1:0]         quo_next;
    ffgm_pkg::rd_rsp_t                   out_reg;
    ffgm_pkg::rd_rsp_t                   out_next;

    logic [ffgm_pkg::PROD_W-1:0]         prod;
    logic                                overflow;
    logic [ffgm_pkg::TOTAL_W:0]          shifted;
    logic                                fits;

    // Product, saturation compare and one division step
    assign prod     = sum_reg * count_reg;
    assign overflow = ({3'b000, num_reg} >= {total_reg, {ffgm_pkg::GAIN_W{1'b0}}});
    assign shifted  = {rem_reg, lo_reg[ffgm_pkg::GAIN_W-1]};
    assign fits     = (shifted >= {1'b0, total_reg});

    // Phase sequencing and datapath updates
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        total_next = total_reg;
        last_next  = last_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        quo_next   = quo_reg;
        out_next   = out_reg;
        out_next.done = 1'b0;

        case (phase_reg)
            ffgm_pkg::DV_IDLE:
            begin
                if (req.valid)
                begin
                    sum_next   = req.sum;
                    count_next = req.count;
                    total_next = req.total;
                    last_next  = req.last;
                    phase_next = ffgm_pkg::DV_MUL;
                end
            end
            ffgm_pkg::DV_MUL:
            begin
                num_next   = {prod, {ffgm_pkg::FRAC_W{1'b0}}};
                phase_next = ffgm_pkg::DV_CHK;
            end
            ffgm_pkg::DV_CHK:
            begin
                // Zero total or a quotient past the Q4.16 range ends here
                if (total_reg == '0)
                begin
                    out_next.done   = 1'b1;
                    out_next.gain   = '0;
                    out_next.status = ffgm_pkg::STAT_ZERO_TOTAL;
                    out_next.last   = last_reg;
                    phase_next      = ffgm_pkg::DV_IDLE;
                end
                else if (overflow)
                begin
                    out_next.done   = 1'b1;
                    out_next.gain   = ffgm_pkg::GAIN_MAX;
                    out_next.status = ffgm_pkg::STAT_OK;
                    out_next.last   = last_reg;
                    phase_next      = ffgm_pkg::DV_IDLE;
                end
                else
                begin
                    rem_next   = ffgm_pkg::TOTAL_W'(num_reg[ffgm_pkg::NUM_W-1:ffgm_pkg::GAIN_W]);
                    lo_next    = num_reg[ffgm_pkg::GAIN_W-1:0];
                    quo_next   = '0;
                    step_next  = ffgm_pkg::STEP_W'(ffgm_pkg::GAIN_W - 1);
                    phase_next = ffgm_pkg::DV_STEP;
                end
            end
            ffgm_pkg::DV_STEP:
            begin
                rem_next  = fits ? ffgm_pkg::TOTAL_W'(shifted - {1'b0, total_reg})
                                 : shifted[ffgm_pkg::TOTAL_W-1:0];
                lo_next   = {lo_reg[ffgm_pkg::GAIN_W-2:0], 1'b0};
                quo_next  = {quo_reg[ffgm_pkg::GAIN_W-2:0], fits};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    out_next.done   = 1'b1;
                    out_next.gain   = {quo_reg[ffgm_pkg::GAIN_W-2:0], fits};
                    out_next.status = ffgm_pkg::STAT_OK;
                    out_next.last   = last_reg;
                    phase_next      = ffgm_pkg::DV_IDLE;
                end
            end
            default:
            begin
                phase_next = ffgm_pkg::DV_IDLE;
            end
        endcase
    end

    // Control registers and the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ffgm_pkg::DV_IDLE;
            out_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            out_reg   <= out_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        sum_reg        <= sum_next;
        count_reg      <= count_next;
        total_reg      <= total_next;
        last_reg       <= last_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        lo_reg         <= lo_next;
        quo_reg        <= quo_next;
    end

    assign rsp = out_reg;

    `FFGM_ASSERT(a_req_when_idle, req.valid |-> phase_reg == ffgm_pkg::DV_IDLE, "request while busy")
    `FFGM_ASSERT_NEXT(a_done_pulse, out_reg.done, !out_reg.done, "result strobe longer than one cycle")
    `FFGM_ASSERT_NEXT(a_zero_total, phase_reg == ffgm_pkg::DV_CHK && total_reg == '0, out_reg.done && out_reg.status == ffgm_pkg::STAT_ZERO_TOTAL, "zero total not flagged")

endmodule

// ===== rtl/flat_field_gain_map.sv =====
// ---------------------------------------------------------------------------
// Flat-field gain map, dark subtracted, unit-mean normalised
// Accumulates dark-corrected flat pixels per pixel and in a grand total, and
// reads out gain = sum * pixel_count * 2^16 / total in unsigned Q4.16.
//
// Channel   Direction  Handshake              Word
// input     in         start & !busy          op, pixel_index, flat_value,
//                                             dark_value, first_frame
// result    out        done (one cycle)       gain, status, last
// config    in         cfg_we                 cfg_addr, cfg_wdata
//
// Accumulate: words are taken back to back; the sum RAM read is registered
// and the write-back overlaps the next word (forwarded on an address clash).
// Readout: accept, RAM read, multiply, range check, 20 division steps and the
// output register lead to the done strobe; a zero total or a saturated gain
// skips the division steps. busy is high until done.
// Reset clears the control, the configuration and the grand total; the sum
// RAM is not cleared. Out-of-range words are taken and dropped.
// ---------------------------------------------------------------------------
`include "flat_field_gain_map_macros.svh"

module flat_field_gain_map #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [ffgm_pkg::IDX_W-1:0]    pixel_index,
    input  logic [ffgm_pkg::DATA_W-1:0]   flat_value,
    input  logic [ffgm_pkg::DATA_W-1:0]   dark_value,
    input  logic                          first_frame,
    output logic                          done,
    output logic [ffgm_pkg::GAIN_W-1:0]   gain,
    output logic                          status,
    output logic                          last,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [ffgm_pkg::COUNT_W-1:0]  cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_PIXELS);

    ffgm_pkg::state_t              state_reg;
    ffgm_pkg::state_t              state_next;
    logic [ffgm_pkg::COUNT_W-1:0]  pixel_count_reg;
    logic                          dark_enable_reg;
    logic                          last_reg;

    logic [ffgm_pkg::COUNT_W-1:0]  count;
    logic                          in_range;
    logic                          accept;
    logic                          rd_issue;
    logic                          acc_issue;
    logic                          rd_hit;
    logic                          is_last;
    logic [31:0]                   idx_ext;
    logic [ADDR_W-1:0]             addr;

    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [ffgm_pkg::SUM_W-1:0]    mem_wdata;
    logic [ffgm_pkg::SUM_W-1:0]    rdata;
    logic [ffgm_pkg::SUM_W-1:0]    sum_rd;
    logic [ffgm_pkg::TOTAL_W-1:0]  total;

    ffgm_pkg::rd_req_t             req;
    ffgm_pkg::rd_rsp_t             rsp;

    // Clamp the pixel count to the RAM depth
    always_comb
    begin
        if (32'(pixel_count_reg) > 32'(MAX_PIXELS))
        begin
            count = ffgm_pkg::COUNT_W'(MAX_PIXELS);
        end
        else
        begin
            count = pixel_count_reg;
        end
    end

    assign idx_ext   = 32'(pixel_index);
    assign addr      = idx_ext[ADDR_W-1:0];
    assign in_range  = ({1'b0, pixel_index} < count);
    assign is_last   = ({1'b0, pixel_index} == (count - 1'b1));
    assign busy      = (state_reg != ffgm_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign rd_issue  = accept && in_range;
    assign acc_issue = rd_issue && (ffgm_pkg::op_t'(op) == ffgm_pkg::OP_ACCUM);
    assign rd_hit    = rd_issue && (ffgm_pkg::op_t'(op) == ffgm_pkg::OP_READ);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= ffgm_pkg::COUNT_RESET;
            dark_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (ffgm_pkg::cfg_idx_t'(cfg_addr))
                ffgm_pkg::CFG_PIXEL_COUNT: pixel_count_reg <= cfg_wdata;
                ffgm_pkg::CFG_DARK_ENABLE: dark_enable_reg <= cfg_wdata[0];
                default:                   pixel_count_reg <= pixel_count_reg;
            endcase
        end
    end

    // Control state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffgm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the last flag of a readout word
    always_ff @(posedge clk)
    begin
        if (rd_hit)
        begin
            last_reg <= is_last;
        end
    end

    // Next state and readout request
    always_comb
    begin
        state_next = state_reg;
        req.valid  = 1'b0;
        req.sum    = sum_rd;
        req.count  = count;
        req.total  = total;
        req.last   = last_reg;
        case (state_reg)
            ffgm_pkg::ST_IDLE:
            begin
                if (rd_hit)
                begin
                    state_next = ffgm_pkg::ST_RD_WAIT;
                end
            end
            ffgm_pkg::ST_RD_WAIT:
            begin
                req.valid  = 1'b1;
                state_next = ffgm_pkg::ST_DIV;
            end
            ffgm_pkg::ST_DIV:
            begin
                if (rsp.done)
                begin
                    state_next = ffgm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffgm_pkg::ST_IDLE;
            end
        endcase
    end

    ffgm_ram #(
        .WIDTH (ffgm_pkg::SUM_W),
        .DEPTH (MAX_PIXELS)
    ) u_sums (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    ffgm_acc #(
        .ADDR_W (ADDR_W)
    ) u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_issue    (rd_issue),
        .acc_issue   (acc_issue),
        .addr        (addr),
        .flat_value  (flat_value),
        .dark_value  (dark_value),
        .first_frame (first_frame),
        .dark_enable (dark_enable_reg),
        .rdata       (rdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .sum_rd      (sum_rd),
        .total       (total)
    );

    ffgm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign done   = rsp.done;
    assign gain   = rsp.gain;
    assign status = rsp.status;
    assign last   = rsp.last;

    `FFGM_ASSERT(a_done_in_div, done |-> state_reg == ffgm_pkg::ST_DIV, "result outside readout")
    `FFGM_ASSERT_NEXT(a_rd_enter, rd_hit, state_reg == ffgm_pkg::ST_RD_WAIT, "readout not started")
    `FFGM_ASSERT(a_no_wb_busy, busy |-> !mem_we, "sum write-back during readout")

endmodule

// ===== sim/ffgm_gain_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Flat-field gain map checker
// Watches the input, result and register channels of the gain map, keeps
// its own copy of the pixel sums, the frame total and the registers, works
// out the result word of every accepted readout and compares each strobed
// result with the oldest one still due. Hands the failure count and the
// number of results still due to the testbench top.
// ---------------------------------------------------------------------------
module ffgm_gain_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          op,
    input  logic [ffgm_pkg::IDX_W-1:0]    pixel_index,
    input  logic [ffgm_pkg::DATA_W-1:0]   flat_value,
    input  logic [ffgm_pkg::DATA_W-1:0]   dark_value,
    input  logic                          first_frame,
    input  logic                          done,
    input  logic [ffgm_pkg::GAIN_W-1:0]   gain,
    input  logic                          status,
    input  logic                          last,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [ffgm_pkg::COUNT_W-1:0]  cfg_wdata,
    output int unsigned                   mismatches,
    output int unsigned                   awaited
);

    import ffgm_pkg::*;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        status_t           status;
        logic              last;
    } gain_word_t;

    gain_word_t         gains_due [$];
    logic [SUM_W-1:0]   pixel_acc [0:65535];
    logic [TOTAL_W-1:0] frame_total;
    logic [COUNT_W-1:0] count_reg;
    logic               dark_reg;

    // Add into the frame total, saturating at the top
    function automatic logic [TOTAL_W-1:0] total_plus(input logic [TOTAL_W-1:0] t,
                                                      input logic [SUM_W:0] amt);
        logic [TOTAL_W:0] s;
        s = {1'b0, t} + (TOTAL_W+1)'(amt);
        return (s > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    // Apply one accepted word to the pixel sums and queue any gain it yields
    task automatic take_word(input op_t w_op, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] flat, input logic [DATA_W-1:0] dark,
                             input logic first);
        logic [COUNT_W-1:0] in_use;
        logic [DATA_W-1:0]  corr;
        logic [SUM_W-1:0]   old_sum;
        logic [SUM_W:0]     new_sum;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        quo;
        gain_word_t         w;
        in_use = (count_reg > COUNT_RESET) ? COUNT_RESET : count_reg;
        // drop words whose index lies past the frame in use
        if ({1'b0, idx} < in_use)
        begin
            if (w_op == OP_ACCUM)
            begin
                if (dark_reg)
                    corr = (flat > dark) ? flat - dark : '0;
                else
                    corr = flat;
                if (first)
                begin
                    // first frame overwrites; pixel zero restarts the total
                    if (idx == '0)
                        frame_total = '0;
                    pixel_acc[idx] = {{(SUM_W-DATA_W){1'b0}}, corr};
                    frame_total = total_plus(frame_total, {{(SUM_W-DATA_W+1){1'b0}}, corr});
                end
                else
                begin
                    old_sum = pixel_acc[idx];
                    new_sum = {1'b0, old_sum} + (SUM_W+1)'(corr);
                    if (new_sum > {1'b0, SUM_MAX})
                        new_sum = {1'b0, SUM_MAX};
                    pixel_acc[idx] = new_sum[SUM_W-1:0];
                    frame_total = total_plus(frame_total, new_sum - {1'b0, old_sum});
                end
            end
            else
            begin
                w.last = ({1'b0, idx} == in_use - 1'b1);
                if (frame_total == '0)
                begin
                    w.gain   = '0;
                    w.status = STAT_ZERO_TOTAL;
                end
                else
                begin
                    num = 64'(pixel_acc[idx]);
                    num = num * 64'(in_use);
                    num = num << FRAC_W;
                    den = 64'(frame_total);
                    quo = num / den;
                    w.gain   = (quo > 64'(GAIN_MAX)) ? GAIN_MAX : quo[GAIN_W-1:0];
                    w.status = STAT_OK;
                end
                gains_due.push_back(w);
            end
        end
    endtask

    // Compare one strobed result with the oldest gain still due
    task automatic check_result();
        gain_word_t want;
        if (gains_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result word: gain %h status %0d last %0d",
                         $realtime, gain, status, last);
        end
        else
        begin
            want = gains_due.pop_front();
            if (gain !== want.gain || status !== want.status || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result word: expected gain %h status %0d last %0d,",
                              " got gain %h status %0d last %0d"},
                             $realtime, want.gain, want.status, want.last,
                             gain, status, last);
            end
        end
    endtask

    // Track results first, then new words, then register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_due.delete();
            frame_total = '0;
            count_reg   = COUNT_RESET;
            dark_reg    = 1'b0;
            mismatches  = 0;
            awaited     = 0;
        end
        else
        begin
            if (done)
                check_result();
            if (start && !busy)
                take_word(op_t'(op), pixel_index, flat_value, dark_value, first_frame);
            if (cfg_we)
            begin
                if (cfg_addr == CFG_PIXEL_COUNT)
                    count_reg = cfg_wdata;
                else
                    dark_reg = cfg_wdata[0];
            end
            awaited = gains_due.size();
        end
    end

endmodule

// ===== sim/flat_field_gain_map_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Flat-field gain map testbench
// Drives accumulate and readout words into the gain map: a directed pass over
// the field extremes, zero totals, saturation and out-of-range indices, then
// random frame sets, wide frames, noise bursts and one long accumulation into
// a single pixel. A checker beside the block predicts and compares results.
// ---------------------------------------------------------------------------
module flat_field_gain_map_tb;

    import ffgm_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                op;
    logic [IDX_W-1:0]    pixel_index;
    logic [DATA_W-1:0]   flat_value;
    logic [DATA_W-1:0]   dark_value;
    logic                first_frame;
    logic                done;
    logic [GAIN_W-1:0]   gain;
    logic                status;
    logic                last;
    logic                cfg_we;
    logic                cfg_addr;
    logic [COUNT_W-1:0]  cfg_wdata;
    int unsigned         mismatches;
    int unsigned         awaited;

    // Stimulus bookkeeping: pixels in use, sums ever loaded, words taken
    int unsigned         in_use = 65536;
    int unsigned         sent = 0;
    int unsigned         idle_pct = 11;
    bit                  loaded [0:65535];
    bit                  hammered = 1'b0;

    flat_field_gain_map DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .pixel_index (pixel_index),
        .flat_value  (flat_value),
        .dark_value  (dark_value),
        .first_frame (first_frame),
        .done        (done),
        .gain        (gain),
        .status      (status),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    ffgm_gain_checker gain_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .pixel_index (pixel_index),
        .flat_value  (flat_value),
        .dark_value  (dark_value),
        .first_frame (first_frame),
        .done        (done),
        .gain        (gain),
        .status      (status),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .awaited     (awaited)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Offer one word and hold it until taken; steer clear of unloaded sums
    task automatic send_word(input op_t w_op, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] flat, input logic [DATA_W-1:0] dark,
                             input logic first);
        bit   hit;
        op_t  o;
        logic f;
        o   = w_op;
        f   = first;
        hit = (32'(idx) < in_use);
        if (hit && !loaded[idx])
        begin
            o = OP_ACCUM;
            f = 1'b1;
        end
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        op          <= o;
        pixel_index <= idx;
        flat_value  <= flat;
        dark_value  <= dark;
        first_frame <= f;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (hit)
        begin
            sent++;
            if (o == OP_ACCUM)
                loaded[idx] = 1'b1;
        end
    endtask

    // Hold off until every gain has come and the block has gone quiet
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (awaited != 0 || busy)
            @(negedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t r, input logic [COUNT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (r == CFG_PIXEL_COUNT)
            in_use = (v > COUNT_RESET) ? 65536 : 32'(v);
    endtask

    task automatic reconfigure(input logic [COUNT_W-1:0] count, input logic dark_on);
        drain();
        write_reg(CFG_PIXEL_COUNT, count);
        write_reg(CFG_DARK_ENABLE, {{(COUNT_W-1){1'b0}}, dark_on});
    endtask

    // Load a small frame set, add further frames, then read the map back
    task automatic frame_set();
        int unsigned n;
        int unsigned frames;
        int unsigned hot;
        int unsigned cut;
        int unsigned style;
        int unsigned f;
        int unsigned p;
        logic [DATA_W-1:0] fl;
        logic [DATA_W-1:0] dk;
        style = $urandom_range(9);
        if ($urandom_range(9) == 0)
            n = 1;
        else if (style < 2)
            n = $urandom_range(20, 40);
        else
            n = $urandom_range(2, 24);
        reconfigure(COUNT_W'(n), 1'($urandom_range(1)));
        frames = $urandom_range(1, 4);
        hot    = $urandom_range(n - 1);
        for (f = 0; f < frames; f++)
        begin
            // broken sets stop a frame part way through
            cut = (style == 3 && $urandom_range(1)) ? $urandom_range(n - 1) : n;
            for (p = 0; p < cut; p++)
            begin
                fl = DATA_W'($urandom);
                dk = DATA_W'($urandom);
                if (style < 2)
                begin
                    // one hot pixel over a dim field drives the gain into saturation
                    fl = (p == hot) ? 16'hFFFF : DATA_W'($urandom_range(255));
                    dk = DATA_W'($urandom_range(255));
                end
                else if (style == 2)
                    dk = 16'hFFFF;
                send_word(OP_ACCUM, IDX_W'(p), fl, dk, f == 0);
            end
        end
        for (p = 0; p < n; p++)
            send_word(OP_READ, IDX_W'((style == 3) ? $urandom_range(n - 1) : p),
                      DATA_W'($urandom), DATA_W'($urandom), 1'($urandom_range(1)));
        if ($urandom_range(3) == 0)
            send_word(OP_READ, IDX_W'(n + $urandom_range(5)),
                      DATA_W'($urandom), DATA_W'($urandom), 1'b0);
    endtask

    // Scatter a few pixels over a large or full-size frame and read them back
    task automatic wide_set();
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   spots [6];
        int unsigned        k;
        case ($urandom_range(4))
            0: count = COUNT_RESET;
            1: count = '1;
            2: count = COUNT_RESET + 1'b1;
            3: count = 17'h0FFFF;
            default: count = COUNT_W'($urandom_range(300, 65535));
        endcase
        reconfigure(count, 1'($urandom_range(1)));
        for (k = 0; k < 6; k++)
        begin
            spots[k] = IDX_W'((k == 0) ? in_use - 1 : $urandom_range(in_use - 1));
            send_word(OP_ACCUM, spots[k], DATA_W'($urandom), DATA_W'($urandom),
                      1'($urandom_range(1)));
        end
        for (k = 0; k < 6; k++)
            send_word(OP_READ, spots[k], DATA_W'($urandom), DATA_W'($urandom),
                      1'($urandom_range(1)));
    endtask

    // Unstructured words, often past the frame or into an empty frame
    task automatic noise_burst();
        int unsigned len;
        int unsigned k;
        if ($urandom_range(2) == 0)
        begin
            case ($urandom_range(2))
                0: reconfigure('0, 1'($urandom_range(1)));
                1: reconfigure(COUNT_W'($urandom_range(1, 30)), 1'($urandom_range(1)));
                default: reconfigure('1, 1'($urandom_range(1)));
            endcase
        end
        len = $urandom_range(8, 24);
        for (k = 0; k < len; k++)
            send_word(op_t'($urandom_range(1)),
                      IDX_W'($urandom_range(1) ? $urandom_range(40) : $urandom),
                      DATA_W'($urandom), DATA_W'($urandom), 1'($urandom_range(1)));
    endtask

    // Pile bright samples into one pixel until its sum saturates
    task automatic hammer();
        int unsigned k;
        reconfigure(COUNT_W'(1), 1'b0);
        send_word(OP_ACCUM, '0, 16'hFFFF, DATA_W'($urandom), 1'b1);
        for (k = 0; k < 300; k++)
        begin
            send_word(OP_ACCUM, '0, DATA_W'($urandom_range(16'hF000, 16'hFFFF)),
                      DATA_W'($urandom), 1'b0);
            if (k % 60 == 59)
                send_word(OP_READ, '0, DATA_W'($urandom), DATA_W'($urandom), 1'b0);
        end
        send_word(OP_READ, '0, DATA_W'($urandom), DATA_W'($urandom), 1'b0);
    endtask

    initial
    begin : stimulus
        int unsigned pick;
        start       <= 1'b0;
        op          <= OP_ACCUM;
        pixel_index <= '0;
        flat_value  <= '0;
        dark_value  <= '0;
        first_frame <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_addr    <= CFG_PIXEL_COUNT;
        cfg_wdata   <= '0;
        rst_n       <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: full frame, no dark; ends of the raster
        send_word(OP_ACCUM, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
        send_word(OP_ACCUM, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
        send_word(OP_READ,  16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        send_word(OP_READ,  16'h0000, 16'h0000, 16'h0000, 1'b0);

        // Four pixels with dark subtraction: zero total, flooring, last pixel
        reconfigure(COUNT_W'(4), 1'b1);
        send_word(OP_ACCUM, 16'd0, 16'd100, 16'd200, 1'b1);
        send_word(OP_READ,  16'd0, 16'h0000, 16'h0000, 1'b0);
        send_word(OP_ACCUM, 16'd1, 16'hFFFF, 16'h0000, 1'b1);
        send_word(OP_ACCUM, 16'd2, 16'd1000, 16'd999, 1'b1);
        send_word(OP_ACCUM, 16'd3, 16'h8000, 16'h7FFF, 1'b1);
        send_word(OP_ACCUM, 16'd1, 16'hFFFF, 16'h0000, 1'b0);
        send_word(OP_ACCUM, 16'd3, 16'h5555, 16'hAAAA, 1'b0);
        send_word(OP_ACCUM, 16'd4, 16'hFFFF, 16'h0000, 1'b1);
        send_word(OP_READ,  16'd4, 16'h0000, 16'h0000, 1'b0);
        send_word(OP_READ,  16'd3, 16'hAAAA, 16'h5555, 1'b1);
        send_word(OP_READ,  16'd1, 16'h0000, 16'h0000, 1'b0);
        send_word(OP_READ,  16'd2, 16'h0000, 16'h0000, 1'b0);

        // Empty frame takes nothing; oversized count acts as full frame
        reconfigure('0, 1'b0);
        send_word(OP_READ,  16'd0, 16'h0000, 16'h0000, 1'b0);
        send_word(OP_ACCUM, 16'd0, 16'h1234, 16'h0000, 1'b1);
        reconfigure('1, 1'b0);
        send_word(OP_READ,  16'hFFFF, 16'h0000, 16'h0000, 1'b0);

        // Random part in three idling phases
        sent = 0;
        while (sent < 1850)
        begin
            idle_pct = (sent < 620) ? 11 : (sent < 1240) ? 49 : 0;
            pick = $urandom_range(99);
            if (!hammered && sent >= 800)
            begin
                hammer();
                hammered = 1'b1;
            end
            else if (pick < 65)
                frame_set();
            else if (pick < 80)
                wide_set();
            else
                noise_burst();
        end

        drain();
        if (mismatches == 0 && awaited == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== flat_field_gain_map.f =====
+incdir+rtl
rtl/ffgm_pkg.sv
rtl/ffgm_ram.sv
rtl/ffgm_acc.sv
rtl/ffgm_div.sv
rtl/flat_field_gain_map.sv
sim/ffgm_gain_checker.sv
sim/flat_field_gain_map_tb.sv
